>>> rtl/tds_pkg.sv
// Shared types and constants for the tridiagonal solver.
// Used by every module of the solver and by its checker; depends on nothing.
package tds_pkg;

    localparam int MAX_N_DEF     = 64;
    localparam int FRAC_BITS_DEF = 16;
    // Widest row count the block supports (MAX_N up to 64) and the row index width.
    localparam int NUM_W     = 7;
    localparam int ROW_IDX_W = 6;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } t_row_in;

    typedef struct packed {
        logic signed [31:0]     solution;
        logic [ROW_IDX_W-1:0]   row_index;
        logic                   last_solution;
        logic                   solve_error;
    } t_result_out;

    typedef struct packed {
        logic               we;
        logic [NUM_W-2:0]   addr;
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs_value;
    } t_row_wr;

    typedef struct packed {
        logic [NUM_W-1:0] rows;
        logic             periodic;
        logic             forced;
    } t_solve_cmd;

endpackage

>>> rtl/tds_front.sv
// Front end of the tridiagonal solver: row intake, row counting and solve classification.
// Depends on tds_pkg.
module tds_front
    import tds_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_row_in    i_row,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output t_row_wr    o_wr,
    output logic       o_push,
    output t_solve_cmd o_cmd
);

    localparam int CW = $clog2(MAX_N + 1);

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_periodic;

    logic          room;
    logic [CW-1:0] rows_now;
    logic          ovf_now;

    assign room     = (r_count < CW'(MAX_N));
    assign rows_now = room ? r_count + CW'(1) : r_count;
    assign ovf_now  = r_ovf | ~room;

    always_comb begin
        o_wr.we         = i_accept & room;
        o_wr.addr       = (NUM_W - 1)'(r_count);
        o_wr.sub_diag   = i_row.sub_diag;
        o_wr.main_diag  = i_row.main_diag;
        o_wr.super_diag = i_row.super_diag;
        o_wr.rhs_value  = i_row.rhs_value;
    end

    assign o_push         = i_accept & i_row.last_row;
    assign o_cmd.rows     = NUM_W'(rows_now);
    assign o_cmd.periodic = r_periodic;
    // Too many rows, or a cyclic system too small for corner terms, skips the solve.
    assign o_cmd.forced   = ovf_now | (r_periodic & (rows_now < CW'(3)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_periodic <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_periodic <= i_cfg_wdata;
            end
            if (i_accept) begin
                if (i_row.last_row) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_count <= rows_now;
                    r_ovf   <= ovf_now;
                end
            end
        end
    end

endmodule

>>> rtl/tds_cmdq.sv
// Two-entry command queue between the solver front end and back end.
// Depends on tds_pkg.
module tds_cmdq
    import tds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_solve_cmd i_cmd,
    input  logic       i_pop,
    output logic       o_valid,
    output t_solve_cmd o_cmd
);

    t_solve_cmd r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;

    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && r_fill != 2'd2) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push && r_fill != 2'd2) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop && o_valid) begin
                r_rptr <= ~r_rptr;
            end
            priority case ({i_push && r_fill != 2'd2, i_pop && o_valid})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> rtl/tds_div.sv
// Iterative signed fixed-point divider, one quotient bit per cycle, saturating.
// Depends on tds_pkg.
module tds_div
    import tds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot,
    output logic               o_zero
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int SW = $clog2(DW + 1);
    localparam logic [DW-1:0] LIM = {{(DW - 32){1'b0}}, 32'h8000_0000};

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [32:0]   r_rem;
    logic [31:0]   r_dv;
    logic          r_neg;
    logic          r_zero;
    logic          r_numneg;

    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] rem_sh;
    logic        qbit;

    assign num_mag = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign den_mag = i_den[31] ? (~i_den + 32'd1) : i_den;
    assign rem_sh  = {r_rem[31:0], r_dvd[DW-1]};
    assign qbit    = (rem_sh >= {1'b0, r_dv});

    always_comb begin
        if (r_zero) begin
            o_quot = r_numneg ? Q_MIN : Q_MAX;
        end else if (r_neg) begin
            o_quot = (r_dvd > LIM) ? Q_MIN : -$signed(r_dvd[31:0]);
        end else begin
            o_quot = (r_dvd >= LIM) ? Q_MAX : $signed(r_dvd[31:0]);
        end
    end

    assign o_done = r_done;
    assign o_zero = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd    <= {num_mag, {FRAC_BITS{1'b0}}};
                r_rem    <= '0;
                r_dv     <= den_mag;
                r_neg    <= i_num[31] ^ i_den[31];
                r_numneg <= i_num[31];
                r_zero   <= (i_den == 32'sd0);
                r_cnt    <= SW'(DW);
                // A zero divisor needs no iterations.
                r_busy   <= (i_den != 32'sd0);
                r_done   <= (i_den == 32'sd0);
            end else if (r_busy) begin
                r_rem <= qbit ? rem_sh - {1'b0, r_dv} : rem_sh;
                r_dvd <= {r_dvd[DW-2:0], qbit};
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/tds_back.sv
// Back end of the tridiagonal solver: row stores, elimination and substitution
// sequencer with a shared multiply-subtract step and divider, and result output.
// Depends on tds_pkg and tds_div.
module tds_back
    import tds_pkg::*;
#(
    parameter int MAX_N     = MAX_N_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_row_wr     i_wr,
    input  logic        i_cmd_valid,
    input  t_solve_cmd  i_cmd,
    output logic        o_cmd_pop,
    output logic        o_busy,
    output logic        o_result_valid,
    output t_result_out o_result
);

    localparam int AW = $clog2(MAX_N);
    localparam int CW = $clog2(MAX_N + 1);

    typedef enum logic [1:0] {
        SEL_B,
        SEL_F,
        SEL_FC
    } t_wsel;

    typedef enum logic [5:0] {
        ST_IDLE, ST_RDW, ST_MUL, ST_SUB, ST_DIV,
        ST_P_LD0D, ST_P_RD, ST_P_RDD, ST_P_F1, ST_P_F2, ST_P_F3,
        ST_P_LAST, ST_P_L1, ST_P_BRD, ST_P_BRDD, ST_P_B1, ST_P_B2,
        ST_C_LD0D, ST_C_LDLD, ST_C_RD, ST_C_RDD,
        ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8,
        ST_C_T, ST_C_TD,
        ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7,
        ST_T8, ST_T9, ST_T10, ST_T11, ST_T12, ST_T13, ST_T14,
        ST_CB_RD, ST_CB_D, ST_CB1, ST_CB2, ST_CB3,
        ST_EM, ST_EMD
    } t_state;

    // Row stores and the fill-in column.
    logic signed [31:0] mem_a  [MAX_N];
    logic signed [31:0] mem_b  [MAX_N];
    logic signed [31:0] mem_c  [MAX_N];
    logic signed [31:0] mem_f  [MAX_N];
    logic signed [31:0] mem_fc [MAX_N];
    logic signed [31:0] rd_a, rd_b, rd_c, rd_f, rd_fc;

    t_state             r_state;
    t_state             r_ret;
    logic [AW-1:0]      r_raddr;
    logic               r_bwe;
    t_wsel              r_bsel;
    logic [AW-1:0]      r_baddr;
    logic signed [31:0] r_bdata;

    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_i;
    logic               r_forced;
    logic               r_fault;

    logic signed [31:0] r_opx, r_opa, r_opb;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_res;
    logic               r_dstart;
    logic signed [31:0] r_dnum, r_dden;
    logic signed [31:0] r_q;

    // Values carried from the previous row, the last row's terms and the back-substitution terms.
    logic signed [31:0] r_pb, r_pc, r_pf, r_pfc, r_pfr;
    logic signed [31:0] r_al, r_bl, r_fl;
    logic signed [31:0] r_x, r_xl;
    logic signed [31:0] r_ca, r_cb, r_cc, r_cf, r_cfc;

    logic               r_valid;
    t_result_out        r_out;

    logic               div_done;
    logic signed [31:0] div_quot;
    logic               div_zero;

    function automatic logic signed [31:0] mul_sub(input logic signed [31:0] x,
                                                   input logic signed [63:0] p);
        logic signed [63:0] sh;
        logic signed [31:0] m;
        logic        [32:0] d;
        sh = p >>> FRAC_BITS;
        if (sh > 64'sh0000_0000_7fff_ffff) begin
            m = Q_MAX;
        end else if (sh < 64'shffff_ffff_8000_0000) begin
            m = Q_MIN;
        end else begin
            m = sh[31:0];
        end
        d = {x[31], x} - {m[31], m};
        if (d[32] != d[31]) begin
            return d[32] ? Q_MIN : Q_MAX;
        end
        return $signed(d[31:0]);
    endfunction

    tds_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_zero  (div_zero)
    );

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem_a[AW'(i_wr.addr)] <= i_wr.sub_diag;
            mem_b[AW'(i_wr.addr)] <= i_wr.main_diag;
            mem_c[AW'(i_wr.addr)] <= i_wr.super_diag;
            mem_f[AW'(i_wr.addr)] <= i_wr.rhs_value;
        end else if (r_bwe) begin
            unique case (r_bsel)
                SEL_B:   mem_b[r_baddr]  <= r_bdata;
                SEL_F:   mem_f[r_baddr]  <= r_bdata;
                SEL_FC:  mem_fc[r_baddr] <= r_bdata;
                default: mem_f[r_baddr]  <= r_bdata;
            endcase
        end
        rd_a  <= mem_a[r_raddr];
        rd_b  <= mem_b[r_raddr];
        rd_c  <= mem_c[r_raddr];
        rd_f  <= mem_f[r_raddr];
        rd_fc <= mem_fc[r_raddr];
    end

    assign o_cmd_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_bwe    <= 1'b0;
            r_dstart <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_bwe    <= 1'b0;
            r_dstart <= 1'b0;
            r_valid  <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_n      <= CW'(i_cmd.rows);
                        r_forced <= i_cmd.forced;
                        r_fault  <= 1'b0;
                        r_i      <= '0;
                        r_raddr  <= '0;
                        if (i_cmd.forced) begin
                            r_state <= ST_EM;
                        end else begin
                            r_ret   <= i_cmd.periodic ? ST_C_LD0D : ST_P_LD0D;
                            r_state <= ST_RDW;
                        end
                    end
                end
                ST_RDW: r_state <= r_ret;
                ST_MUL: begin
                    r_prod  <= r_opa * r_opb;
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_res   <= mul_sub(r_opx, r_prod);
                    r_state <= r_ret;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_q     <= div_quot;
                        r_fault <= r_fault | div_zero;
                        r_state <= r_ret;
                    end
                end

                // Plain system: forward elimination.
                ST_P_LD0D: begin
                    r_pb <= rd_b;
                    r_pc <= rd_c;
                    r_pf <= rd_f;
                    r_i  <= CW'(1);
                    r_state <= (r_n == CW'(1)) ? ST_P_LAST : ST_P_RD;
                end
                ST_P_RD: begin
                    r_raddr <= AW'(r_i);
                    r_ret   <= ST_P_RDD;
                    r_state <= ST_RDW;
                end
                ST_P_RDD: begin
                    r_cb <= rd_b;
                    r_cc <= rd_c;
                    r_cf <= rd_f;
                    r_dnum <= rd_a; r_dden <= r_pb; r_dstart <= 1'b1;
                    r_ret <= ST_P_F1; r_state <= ST_DIV;
                end
                ST_P_F1: begin
                    r_opx <= r_cb; r_opa <= r_pc; r_opb <= r_q;
                    r_ret <= ST_P_F2; r_state <= ST_MUL;
                end
                ST_P_F2: begin
                    r_pb <= r_res;
                    r_bwe <= 1'b1; r_bsel <= SEL_B; r_baddr <= AW'(r_i); r_bdata <= r_res;
                    r_opx <= r_cf; r_opa <= r_pf; r_opb <= r_q;
                    r_ret <= ST_P_F3; r_state <= ST_MUL;
                end
                ST_P_F3: begin
                    r_pf <= r_res;
                    r_pc <= r_cc;
                    r_bwe <= 1'b1; r_bsel <= SEL_F; r_baddr <= AW'(r_i); r_bdata <= r_res;
                    r_i <= r_i + CW'(1);
                    r_state <= ((r_i + CW'(1)) == r_n) ? ST_P_LAST : ST_P_RD;
                end
                ST_P_LAST: begin
                    r_dnum <= r_pf; r_dden <= r_pb; r_dstart <= 1'b1;
                    r_ret <= ST_P_L1; r_state <= ST_DIV;
                end
                ST_P_L1: begin
                    r_x <= r_q;
                    r_bwe <= 1'b1; r_bsel <= SEL_F; r_baddr <= AW'(r_n - CW'(1)); r_bdata <= r_q;
                    r_i <= r_n - CW'(1);
                    r_state <= (r_n == CW'(1)) ? ST_EM : ST_P_BRD;
                end

                // Plain system: back substitution.
                ST_P_BRD: begin
                    r_i     <= r_i - CW'(1);
                    r_raddr <= AW'(r_i - CW'(1));
                    r_ret   <= ST_P_BRDD;
                    r_state <= ST_RDW;
                end
                ST_P_BRDD: begin
                    r_cb <= rd_b;
                    r_opx <= rd_f; r_opa <= r_x; r_opb <= rd_c;
                    r_ret <= ST_P_B1; r_state <= ST_MUL;
                end
                ST_P_B1: begin
                    r_dnum <= r_res; r_dden <= r_cb; r_dstart <= 1'b1;
                    r_ret <= ST_P_B2; r_state <= ST_DIV;
                end
                ST_P_B2: begin
                    r_x <= r_q;
                    r_bwe <= 1'b1; r_bsel <= SEL_F; r_baddr <= AW'(r_i); r_bdata <= r_q;
                    r_state <= (r_i == '0) ? ST_EM : ST_P_BRD;
                end

                // Cyclic system: set up the fill-in column and row from the corner terms.
                ST_C_LD0D: begin
                    r_pb  <= rd_b;
                    r_pc  <= rd_c;
                    r_pf  <= rd_f;
                    r_pfc <= rd_a;
                    r_bwe <= 1'b1; r_bsel <= SEL_FC; r_baddr <= '0; r_bdata <= rd_a;
                    r_raddr <= AW'(r_n - CW'(1));
                    r_ret   <= ST_C_LDLD;
                    r_state <= ST_RDW;
                end
                ST_C_LDLD: begin
                    r_al  <= rd_a;
                    r_bl  <= rd_b;
                    r_fl  <= rd_f;
                    r_pfr <= rd_c;
                    r_i   <= CW'(1);
                    r_state <= (r_n == CW'(3)) ? ST_C_T : ST_C_RD;
                end
                ST_C_RD: begin
                    r_raddr <= AW'(r_i);
                    r_ret   <= ST_C_RDD;
                    r_state <= ST_RDW;
                end
                ST_C_RDD: begin
                    r_cb <= rd_b;
                    r_cc <= rd_c;
                    r_cf <= rd_f;
                    r_dnum <= rd_a; r_dden <= r_pb; r_dstart <= 1'b1;
                    r_ret <= ST_C1; r_state <= ST_DIV;
                end
                ST_C1: begin
                    r_opx <= r_cb; r_opa <= r_pc; r_opb <= r_q;
                    r_ret <= ST_C2; r_state <= ST_MUL;
                end
                ST_C2: begin
                    r_cb <= r_res;
                    r_bwe <= 1'b1; r_bsel <= SEL_B; r_baddr <= AW'(r_i); r_bdata <= r_res;
                    r_opx <= '0; r_opa <= r_pfc; r_opb <= r_q;
                    r_ret <= ST_C3; r_state <= ST_MUL;
                end
                ST_C3: begin
                    r_cfc <= r_res;
                    r_bwe <= 1'b1; r_bsel <= SEL_FC; r_baddr <= AW'(r_i); r_bdata <= r_res;
                    r_opx <= r_cf; r_opa <= r_pf; r_opb <= r_q;
                    r_ret <= ST_C4; r_state <= ST_MUL;
                end
                ST_C4: begin
                    r_cf <= r_res;
                    r_bwe <= 1'b1; r_bsel <= SEL_F; r_baddr <= AW'(r_i); r_bdata <= r_res;
                    r_dnum <= r_pfr; r_dden <= r_pb; r_dstart <= 1'b1;
                    r_ret <= ST_C5; r_state <= ST_DIV;
                end
                ST_C5: begin
                    r_opx <= '0; r_opa <= r_pc; r_opb <= r_q;
                    r_ret <= ST_C6; r_state <= ST_MUL;
                end
                ST_C6: begin
                    r_ca <= r_res;
                    r_opx <= r_bl; r_opa <= r_pfc; r_opb <= r_q;
                    r_ret <= ST_C7; r_state <= ST_MUL;
                end
                ST_C7: begin
                    r_bl <= r_res;
                    r_opx <= r_fl; r_opa <= r_pf; r_opb <= r_q;
                    r_ret <= ST_C8; r_state <= ST_MUL;
                end
                ST_C8: begin
                    r_fl  <= r_res;
                    r_pb  <= r_cb;
                    r_pc  <= r_cc;
                    r_pf  <= r_cf;
                    r_pfc <= r_cfc;
                    r_pfr <= r_ca;
                    r_i   <= r_i + CW'(1);
                    r_state <= ((r_i + CW'(3)) == r_n) ? ST_C_T : ST_C_RD;
                end

                // Cyclic system: the last two rows close the corner terms.
                ST_C_T: begin
                    r_raddr <= AW'(r_i);
                    r_ret   <= ST_C_TD;
                    r_state <= ST_RDW;
                end
                ST_C_TD: begin
                    r_cb <= rd_b;
                    r_cc <= rd_c;
                    r_cf <= rd_f;
                    r_dnum <= rd_a; r_dden <= r_pb; r_dstart <= 1'b1;
                    r_ret <= ST_T1; r_state <= ST_DIV;
                end
                ST_T1: begin
                    r_opx <= r_cb; r_opa <= r_pc; r_opb <= r_q;
                    r_ret <= ST_T2; r_state <= ST_MUL;
                end
                ST_T2: begin
                    r_cb <= r_res;
                    r_opx <= r_cc; r_opa <= r_pfc; r_opb <= r_q;
                    r_ret <= ST_T3; r_state <= ST_MUL;
                end
                ST_T3: begin
                    r_cc <= r_res;
                    r_opx <= r_cf; r_opa <= r_pf; r_opb <= r_q;
                    r_ret <= ST_T4; r_state <= ST_MUL;
                end
                ST_T4: begin
                    r_cf <= r_res;
                    r_dnum <= r_pfr; r_dden <= r_pb; r_dstart <= 1'b1;
                    r_ret <= ST_T5; r_state <= ST_DIV;
                end
                ST_T5: begin
                    r_opx <= r_al; r_opa <= r_pc; r_opb <= r_q;
                    r_ret <= ST_T6; r_state <= ST_MUL;
                end
                ST_T6: begin
                    r_al <= r_res;
                    r_opx <= r_bl; r_opa <= r_pfc; r_opb <= r_q;
                    r_ret <= ST_T7; r_state <= ST_MUL;
                end
                ST_T7: begin
                    r_bl <= r_res;
                    r_opx <= r_fl; r_opa <= r_pf; r_opb <= r_q;
                    r_ret <= ST_T8; r_state <= ST_MUL;
                end
                ST_T8: begin
                    r_fl <= r_res;
                    r_dnum <= r_al; r_dden <= r_cb; r_dstart <= 1'b1;
                    r_ret <= ST_T9; r_state <= ST_DIV;
                end
                ST_T9: begin
                    r_opx <= r_bl; r_opa <= r_cc; r_opb <= r_q;
                    r_ret <= ST_T10; r_state <= ST_MUL;
                end
                ST_T10: begin
                    r_bl <= r_res;
                    r_opx <= r_fl; r_opa <= r_cf; r_opb <= r_q;
                    r_ret <= ST_T11; r_state <= ST_MUL;
                end
                ST_T11: begin
                    r_fl <= r_res;
                    r_dnum <= r_res; r_dden <= r_bl; r_dstart <= 1'b1;
                    r_ret <= ST_T12; r_state <= ST_DIV;
                end
                ST_T12: begin
                    r_xl <= r_q;
                    r_bwe <= 1'b1; r_bsel <= SEL_F; r_baddr <= AW'(r_n - CW'(1)); r_bdata <= r_q;
                    r_opx <= r_cf; r_opa <= r_q; r_opb <= r_cc;
                    r_ret <= ST_T13; r_state <= ST_MUL;
                end
                ST_T13: begin
                    r_dnum <= r_res; r_dden <= r_cb; r_dstart <= 1'b1;
                    r_ret <= ST_T14; r_state <= ST_DIV;
                end
                ST_T14: begin
                    r_x <= r_q;
                    r_bwe <= 1'b1; r_bsel <= SEL_F; r_baddr <= AW'(r_i); r_bdata <= r_q;
                    r_state <= ST_CB_RD;
                end

                // Cyclic system: back substitution with the fill-in column.
                ST_CB_RD: begin
                    r_i     <= r_i - CW'(1);
                    r_raddr <= AW'(r_i - CW'(1));
                    r_ret   <= ST_CB_D;
                    r_state <= ST_RDW;
                end
                ST_CB_D: begin
                    r_cb  <= rd_b;
                    r_cfc <= rd_fc;
                    r_opx <= rd_f; r_opa <= rd_c; r_opb <= r_x;
                    r_ret <= ST_CB1; r_state <= ST_MUL;
                end
                ST_CB1: begin
                    r_opx <= r_res; r_opa <= r_cfc; r_opb <= r_xl;
                    r_ret <= ST_CB2; r_state <= ST_MUL;
                end
                ST_CB2: begin
                    r_dnum <= r_res; r_dden <= r_cb; r_dstart <= 1'b1;
                    r_ret <= ST_CB3; r_state <= ST_DIV;
                end
                ST_CB3: begin
                    r_x <= r_q;
                    r_bwe <= 1'b1; r_bsel <= SEL_F; r_baddr <= AW'(r_i); r_bdata <= r_q;
                    r_state <= (r_i == '0) ? ST_EM : ST_CB_RD;
                end

                // Result output, one row per transfer, row order.
                ST_EM: begin
                    r_raddr <= AW'(r_i);
                    r_ret   <= ST_EMD;
                    r_state <= ST_RDW;
                end
                ST_EMD: begin
                    r_valid             <= 1'b1;
                    r_out.solution      <= r_forced ? Q_MAX : rd_f;
                    r_out.row_index     <= ROW_IDX_W'(r_i);
                    r_out.last_solution <= ((r_i + CW'(1)) == r_n);
                    r_out.solve_error   <= r_forced | r_fault;
                    r_i                 <= r_i + CW'(1);
                    r_state <= ((r_i + CW'(1)) == r_n) ? ST_IDLE : ST_EM;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/tridiagonal_solver_unit.sv
// Top level of the tridiagonal solver: front end, command queue and back end.
// Depends on tds_pkg, tds_front, tds_cmdq and tds_back.
//
// Rows are loaded one per cycle while busy is low; the row with last_row set
// starts the solve. busy stays high through the solve and falls in the cycle
// that shows the last result.
// A solve of n rows takes about 2n divisions in the plain mode and about 3n in
// the periodic mode, all in the shared bit-serial divider, besides the steps of
// the shared multiply-subtract unit. Results then leave in row order, each read
// from the row store before it is shown and each valid for a single cycle; the
// receiver cannot stall them and must take every transfer.
// The periodic flag from i_cfg_wdata is sampled when the final row is taken.
module tridiagonal_solver_unit
    import tds_pkg::*;
#(
    parameter int MAX_N     = MAX_N_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_row_in     i_row,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_result_valid,
    output t_result_out o_result
);

    t_row_wr    row_wr;
    logic       push;
    t_solve_cmd front_cmd;
    logic       q_valid;
    t_solve_cmd q_cmd;
    logic       pop;
    logic       back_busy;

    assign busy = q_valid | back_busy;

    tds_front #(
        .MAX_N (MAX_N)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (start & ~busy),
        .i_row       (i_row),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_wr        (row_wr),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    tds_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tds_back #(
        .MAX_N     (MAX_N),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (row_wr),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_cmd_pop      (pop),
        .o_busy         (back_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

>>> rtl/tds_checker.sv
// Port-level checks for the tridiagonal solver, bound to its top level.
// Depends on tds_pkg and tridiagonal_solver_unit.
module tds_checker
    import tds_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input t_row_in     i_row,
    input logic        o_result_valid,
    input t_result_out o_result
);

    // Every result but the last comes out of a running solve.
    a_result_in_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last_solution) |-> busy)
        else $error("result transfer while not busy");

    // The final row starts a solve.
    a_final_row_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_row.last_row) |=> busy)
        else $error("final row did not start a solve");

    // Each result is read out of the store, so transfers never come back to back.
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results on consecutive cycles");

    // The solve ends with its last result.
    a_last_ends_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_solution) |-> !busy)
        else $error("still busy at the last result");

endmodule

bind tridiagonal_solver_unit tds_checker u_tds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_row          (i_row),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
